[rtl/arm32rp_pkg.sv]
package arm32rp_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef logic [4:0] t_op;
    typedef logic [1:0] t_reg_idx;

    localparam t_op OP_REL32            = 5'd0;
    localparam t_op OP_THM_CALL         = 5'd1;
    localparam t_op OP_BASE_PREL        = 5'd2;
    localparam t_op OP_GOT_PREL         = 5'd3;
    localparam t_op OP_GOT_BREL         = 5'd4;
    localparam t_op OP_CALL             = 5'd5;
    localparam t_op OP_JUMP24           = 5'd6;
    localparam t_op OP_THM_JUMP11       = 5'd7;
    localparam t_op OP_THM_JUMP19       = 5'd8;
    localparam t_op OP_THM_JUMP24       = 5'd9;
    localparam t_op OP_MOVW_PREL_NC     = 5'd10;
    localparam t_op OP_MOVW_ABS_NC      = 5'd11;
    localparam t_op OP_THM_MOVW_PREL_NC = 5'd12;
    localparam t_op OP_THM_MOVW_ABS_NC  = 5'd13;
    localparam t_op OP_MOVT_PREL        = 5'd14;
    localparam t_op OP_THM_MOVT_PREL    = 5'd15;
    localparam t_op OP_MOVT_ABS         = 5'd16;
    localparam t_op OP_THM_MOVT_ABS     = 5'd17;
    localparam t_op OP_PREL31           = 5'd18;
    localparam t_op OP_TLS_LDO32        = 5'd19;
    localparam t_op OP_TLS_LE32         = 5'd20;

    localparam t_reg_idx REG_GOT_BASE       = 2'd0;
    localparam t_reg_idx REG_TLS_BASE       = 2'd1;
    localparam t_reg_idx REG_THREAD_POINTER = 2'd2;

    localparam logic [31:0] NOP_W_THUMB = 32'h8000_f3af;
    localparam logic [31:0] NOP_ARM     = 32'he320_f000;
    localparam logic [31:0] OPC_BL      = 32'heb00_0000;
    localparam logic [31:0] OPC_BLX     = 32'hfa00_0000;
    localparam logic [7:0]  OPC_BL_TOP  = 8'heb;
    localparam logic [6:0]  OPC_BLX_TOP = 7'h7d;
    localparam logic [31:0] THM_BLX_BIT = 32'h1000_0000;

    typedef struct packed {
        logic [31:0] got_base;
        logic [31:0] tls_base;
        logic [31:0] thread_pointer;
    } t_cfg;

    typedef struct packed {
        t_op                operation;
        logic [31:0]        insn_word;
        logic [31:0]        sym_addr;
        logic signed [31:0] addend;
        logic [31:0]        place_addr;
        logic [31:0]        thunk_addr;
        logic [31:0]        got_offset;
        logic               weak_undef;
    } t_req_data;

    typedef struct packed {
        logic [31:0] patched_word;
        logic        bad_call_site;
    } t_rsp_data;

endpackage

[rtl/arm32rp_if.sv]
interface arm32rp_req_if import arm32rp_pkg::*; ();
    logic               valid;
    logic               ready;
    t_op                operation;
    logic [31:0]        insn_word;
    logic [31:0]        sym_addr;
    logic signed [31:0] addend;
    logic [31:0]        place_addr;
    logic [31:0]        thunk_addr;
    logic [31:0]        got_offset;
    logic               weak_undef;

    modport source (
        output valid, operation, insn_word, sym_addr, addend, place_addr,
               thunk_addr, got_offset, weak_undef,
        input  ready
    );
    modport sink (
        input  valid, operation, insn_word, sym_addr, addend, place_addr,
               thunk_addr, got_offset, weak_undef,
        output ready
    );
endinterface

interface arm32rp_rsp_if import arm32rp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] patched_word;
    logic        bad_call_site;

    modport source (
        output valid, patched_word, bad_call_site,
        input  ready
    );
    modport sink (
        input  valid, patched_word, bad_call_site,
        output ready
    );
endinterface

[rtl/arm32rp_cfg.sv]
module arm32rp_cfg import arm32rp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_GOT_BASE:       n_cfg.got_base       = pwdata;
                REG_TLS_BASE:       n_cfg.tls_base       = pwdata;
                REG_THREAD_POINTER: n_cfg.thread_pointer = pwdata;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GOT_BASE:       prdata = r_cfg.got_base;
            REG_TLS_BASE:       prdata = r_cfg.tls_base;
            REG_THREAD_POINTER: prdata = r_cfg.thread_pointer;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/arm32rp_core.sv]
module arm32rp_core import arm32rp_pkg::*; (
    input  t_req_data i_req,
    input  t_cfg      i_cfg,
    output t_rsp_data o_rsp
);

    function automatic logic [31:0] arm_mov(input logic [31:0] w, input logic [15:0] v);
        arm_mov = {w[31:20], v[15:12], w[15:12], v[11:0]};
    endfunction

    function automatic logic [31:0] thm_mov(input logic [31:0] w, input logic [15:0] v);
        thm_mov = {w[31], v[10:8], w[27:24], v[7:0],
                   w[15:11], v[11], w[9:4], v[15:12]};
    endfunction

    function automatic logic [31:0] thm_branch(input logic [31:0] w, input logic [31:0] v);
        logic sb;
        logic j1;
        logic j2;
        sb = v[24];
        j1 = ~v[23] ^ sb;
        j2 = ~v[22] ^ sb;
        thm_branch = {w[31:30], j1, w[28], j2, v[11:1],
                      w[15:11], sb, v[21:12]};
    endfunction

    function automatic logic [31:0] up4(input logic [31:0] v);
        up4 = (v + 32'd3) & ~32'd3;
    endfunction

    logic [31:0] w;
    logic [31:0] s;
    logic [31:0] a;
    logic [31:0] p;
    logic        t;
    logic [31:0] sa;
    logic [31:0] rel;
    logic [31:0] thv;
    logic [31:0] thv4;
    logic [31:0] mv_abs;
    logic [31:0] mv_prel;
    logic [33:0] disp;
    logic        reach;
    logic        call_ok;
    logic [31:0] r;
    logic        bad;

    assign w       = i_req.insn_word;
    assign s       = i_req.sym_addr;
    assign a       = i_req.addend;
    assign p       = i_req.place_addr;
    assign t       = s[0];
    assign sa      = s + a;
    assign rel     = sa - p;
    assign thv     = i_req.thunk_addr + a - p;
    assign thv4    = thv + 32'd4;
    assign mv_abs  = sa | {31'd0, t};
    assign mv_prel = mv_abs - p;
    assign disp    = {2'b00, s} + {{2{a[31]}}, a} - {2'b00, p};
    assign reach   = (disp[33:24] == '0) || (disp[33:24] == '1);
    assign call_ok = (w[31:24] == OPC_BL_TOP) || (w[31:25] == OPC_BLX_TOP);

    always_comb begin
        r   = w;
        bad = 1'b0;
        case (i_req.operation)
            OP_REL32: r = rel;
            OP_THM_CALL: begin
                if (i_req.weak_undef) begin
                    r = NOP_W_THUMB;
                end else if (reach && t) begin
                    r = thm_branch(w, rel) | THM_BLX_BIT;
                end else if (reach) begin
                    r = thm_branch(w, up4(rel)) & ~THM_BLX_BIT;
                end else begin
                    r = thm_branch(w, up4(thv4)) & ~THM_BLX_BIT;
                end
            end
            OP_BASE_PREL: r = i_cfg.got_base + a - p;
            OP_GOT_PREL:  r = i_cfg.got_base + i_req.got_offset + a - p;
            OP_GOT_BREL:  r = i_req.got_offset + a;
            OP_CALL: begin
                if (!call_ok) begin
                    bad = 1'b1;
                end else if (i_req.weak_undef) begin
                    r = NOP_ARM;
                end else if (reach && t) begin
                    r = OPC_BLX | {7'd0, rel[1], rel[25:2]};
                end else if (reach) begin
                    r = OPC_BL | {8'd0, rel[25:2]};
                end else begin
                    r = OPC_BL | {8'd0, thv4[25:2]};
                end
            end
            OP_JUMP24: begin
                if (i_req.weak_undef) begin
                    r = NOP_ARM;
                end else if (!reach || t) begin
                    r = {w[31:24], thv4[25:2]};
                end else begin
                    r = {w[31:24], rel[25:2]};
                end
            end
            OP_THM_JUMP11: r = {w[31:11], rel[11:1]};
            OP_THM_JUMP19: begin
                r = {w[31:30], rel[18], w[28], rel[19], rel[11:1],
                     w[15:11], rel[20], w[9:6], rel[17:12]};
            end
            OP_THM_JUMP24: begin
                if (i_req.weak_undef) begin
                    r = NOP_W_THUMB;
                end else if (!reach || !t) begin
                    r = thm_branch(w, thv);
                end else begin
                    r = thm_branch(w, rel);
                end
            end
            OP_MOVW_PREL_NC:     r = arm_mov(w, mv_prel[15:0]);
            OP_MOVW_ABS_NC:      r = arm_mov(w, mv_abs[15:0]);
            OP_THM_MOVW_PREL_NC: r = thm_mov(w, mv_prel[15:0]);
            OP_THM_MOVW_ABS_NC:  r = thm_mov(w, mv_abs[15:0]);
            OP_MOVT_PREL:        r = arm_mov(w, rel[31:16]);
            OP_THM_MOVT_PREL:    r = thm_mov(w, rel[31:16]);
            OP_MOVT_ABS:         r = arm_mov(w, sa[31:16]);
            OP_THM_MOVT_ABS:     r = thm_mov(w, sa[31:16]);
            OP_PREL31:           r = {w[31], rel[30:0]};
            OP_TLS_LDO32:        r = sa - i_cfg.tls_base;
            OP_TLS_LE32:         r = sa - i_cfg.thread_pointer;
            default:             r = w;
        endcase
    end

    assign o_rsp.patched_word  = r;
    assign o_rsp.bad_call_site = bad;

endmodule

[rtl/arm32_relocation_patch.sv]
// Channel    Role     Handshake      Payload
// i_req      sink     valid/ready    operation, insn_word, sym_addr, addend,
//                                    place_addr, thunk_addr, got_offset, weak_undef
// o_rsp      source   valid/ready    patched_word, bad_call_site
// APB        slave    psel/penable   got_base, tls_base, thread_pointer
//
// A request is registered, patched in one pass of logic, and registered again.
// One request per cycle when the output is not stalled.
// The rate is set by the single compute stage between the two registers.
// Synchronous active-low reset empties both stages and clears the configuration registers.
// When the result is not taken, the input stage still holds one more request.
module arm32_relocation_patch import arm32rp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    arm32rp_req_if.sink           i_req,
    arm32rp_rsp_if.source         o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      w_cfg;
    t_req_data w_req;
    t_rsp_data w_rsp;
    t_req_data r_s1;
    t_rsp_data r_out;
    logic      r_s1_valid;
    logic      n_s1_valid;
    logic      r_out_valid;
    logic      n_out_valid;
    logic      w_adv;
    logic      w_accept;

    arm32rp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    arm32rp_core u_core (
        .i_req (r_s1),
        .i_cfg (w_cfg),
        .o_rsp (w_rsp)
    );

    assign w_req.operation  = i_req.operation;
    assign w_req.insn_word  = i_req.insn_word;
    assign w_req.sym_addr   = i_req.sym_addr;
    assign w_req.addend     = i_req.addend;
    assign w_req.place_addr = i_req.place_addr;
    assign w_req.thunk_addr = i_req.thunk_addr;
    assign w_req.got_offset = i_req.got_offset;
    assign w_req.weak_undef = i_req.weak_undef;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || w_adv;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
        n_out_valid = w_adv ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_req;
        end
        if (w_adv && r_s1_valid) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.patched_word  = r_out.patched_word;
    assign o_rsp.bad_call_site = r_out.bad_call_site;

endmodule

[rtl/arm32rp_checker.sv]
module arm32rp_checker import arm32rp_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic                  i_psel,
    input logic                  i_penable,
    input logic                  i_pwrite,
    input logic [CFG_ADDR_W-1:0] i_paddr,
    input logic [CFG_DATA_W-1:0] i_pwdata,
    input logic [CFG_DATA_W-1:0] i_prdata
);

    // A result turns valid only for a request taken earlier that has passed through the input and output registers.
    a_rsp_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(i_req_valid && i_req_ready, 2))
        else $error("result appeared without a matching request");

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && i_paddr[3:2] == REG_GOT_BASE)
        ##1 (i_psel && !i_pwrite && i_paddr[3:2] == REG_GOT_BASE)
        |-> i_prdata == $past(i_pwdata))
        else $error("register read does not return the written value");

endmodule

bind arm32_relocation_patch arm32rp_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);
